// File: rtl/char_lcd_nibble_sequencer_macros.svh
// Assertion macros for the LCD nibble sequencer.
// Each check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define CLNS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clns: same-cycle check failed");

// Next-cycle implication.
`define CLNS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clns: next-cycle check failed");

`else

`define CLNS_ASSERT_IMP(label, ante, cons)
`define CLNS_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: rtl/clns_pkg.sv
package clns_pkg;

	localparam int BYTE_W = 8;
	localparam int NIB_W  = 4;
	localparam int PC_W   = 5;

	localparam logic [BYTE_W-1:0] CURSOR_ROW1 = 8'h80;
	localparam logic [BYTE_W-1:0] CURSOR_ROW2 = 8'hC0;
	localparam logic [BYTE_W-1:0] WAKE_BYTE   = 8'h03;
	localparam logic [BYTE_W-1:0] FOUR_BYTE   = 8'h02;

	localparam logic [1:0] ROW_ONE = 2'd1;
	localparam logic [1:0] ROW_TWO = 2'd2;

	typedef enum logic [2:0] {
		MODE_DATA   = 3'd0,
		MODE_CMD    = 3'd1,
		MODE_CURSOR = 3'd2,
		MODE_CLEAR  = 3'd3,
		MODE_HOME   = 3'd4,
		MODE_INIT   = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		CFG_FSET  = 3'd0,
		CFG_DON   = 3'd1,
		CFG_ENTRY = 3'd2,
		CFG_CLEAR = 3'd3,
		CFG_HOME  = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		WAIT_NONE = 2'd0,
		WAIT_150  = 2'd1,
		WAIT_2MS  = 2'd2,
		WAIT_5MS  = 2'd3
	} wait_t;

	// operand source of one microcode step
	typedef enum logic [2:0] {
		SRC_OPND  = 3'd0,
		SRC_FSET  = 3'd1,
		SRC_DON   = 3'd2,
		SRC_ENTRY = 3'd3,
		SRC_CLEAR = 3'd4,
		SRC_HOME  = 3'd5,
		SRC_WAKE  = 3'd6,
		SRC_FOUR  = 3'd7
	} src_t;

	typedef struct packed {
		logic [BYTE_W-1:0] fset;
		logic [BYTE_W-1:0] don;
		logic [BYTE_W-1:0] entry;
		logic [BYTE_W-1:0] clear;
		logic [BYTE_W-1:0] home;
	} cfg_words_t;

	typedef struct packed {
		src_t  src;
		logic  hi;    // send high nibble
		logic  rs;
		logic  pre;
		wait_t post;
		logic  done;  // final step, return to idle
	} uword_t;

	// program entry points
	localparam logic [PC_W-1:0] PC_DATA  = 5'd0;
	localparam logic [PC_W-1:0] PC_CMD   = 5'd2;
	localparam logic [PC_W-1:0] PC_CLEAR = 5'd4;
	localparam logic [PC_W-1:0] PC_HOME  = 5'd6;
	localparam logic [PC_W-1:0] PC_INIT  = 5'd8;

	function automatic uword_t mk(src_t s, logic h, logic r, logic p, wait_t w, logic d);
		uword_t u;
		u.src  = s;
		u.hi   = h;
		u.rs   = r;
		u.pre  = p;
		u.post = w;
		u.done = d;
		return u;
	endfunction

	// control store
	function automatic uword_t ucode(logic [PC_W-1:0] pc);
		uword_t u;
		unique case (pc)
			5'd0:    u = mk(SRC_OPND,  1'b1, 1'b1, 1'b0, WAIT_NONE, 1'b0);
			5'd1:    u = mk(SRC_OPND,  1'b0, 1'b1, 1'b0, WAIT_NONE, 1'b1);
			5'd2:    u = mk(SRC_OPND,  1'b1, 1'b0, 1'b0, WAIT_NONE, 1'b0);
			5'd3:    u = mk(SRC_OPND,  1'b0, 1'b0, 1'b0, WAIT_NONE, 1'b1);
			5'd4:    u = mk(SRC_CLEAR, 1'b1, 1'b0, 1'b0, WAIT_NONE, 1'b0);
			5'd5:    u = mk(SRC_CLEAR, 1'b0, 1'b0, 1'b0, WAIT_2MS,  1'b1);
			5'd6:    u = mk(SRC_HOME,  1'b1, 1'b0, 1'b0, WAIT_NONE, 1'b0);
			5'd7:    u = mk(SRC_HOME,  1'b0, 1'b0, 1'b0, WAIT_2MS,  1'b1);
			5'd8:    u = mk(SRC_WAKE,  1'b0, 1'b0, 1'b1, WAIT_5MS,  1'b0);
			5'd9:    u = mk(SRC_WAKE,  1'b0, 1'b0, 1'b0, WAIT_150,  1'b0);
			5'd10:   u = mk(SRC_WAKE,  1'b0, 1'b0, 1'b0, WAIT_NONE, 1'b0);
			5'd11:   u = mk(SRC_FOUR,  1'b0, 1'b0, 1'b0, WAIT_NONE, 1'b0);
			5'd12:   u = mk(SRC_FSET,  1'b1, 1'b0, 1'b0, WAIT_NONE, 1'b0);
			5'd13:   u = mk(SRC_FSET,  1'b0, 1'b0, 1'b0, WAIT_NONE, 1'b0);
			5'd14:   u = mk(SRC_DON,   1'b1, 1'b0, 1'b0, WAIT_NONE, 1'b0);
			5'd15:   u = mk(SRC_DON,   1'b0, 1'b0, 1'b0, WAIT_NONE, 1'b0);
			5'd16:   u = mk(SRC_CLEAR, 1'b1, 1'b0, 1'b0, WAIT_NONE, 1'b0);
			5'd17:   u = mk(SRC_CLEAR, 1'b0, 1'b0, 1'b0, WAIT_2MS,  1'b0);
			5'd18:   u = mk(SRC_ENTRY, 1'b1, 1'b0, 1'b0, WAIT_NONE, 1'b0);
			5'd19:   u = mk(SRC_ENTRY, 1'b0, 1'b0, 1'b0, WAIT_NONE, 1'b1);
			default: u = mk(SRC_OPND,  1'b0, 1'b0, 1'b0, WAIT_NONE, 1'b1);
		endcase
		return u;
	endfunction

endpackage

// File: rtl/char_lcd_nibble_sequencer.sv
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// request  | start, busy               | mode, byte_value, row, column
// strobe   | strobe (one cycle)        | nibble, reg_select, pre_wait, post_wait, last
// config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// A request is dispatched first, then the step counter walks the control store
// with one strobe per step: two for a byte mode, twelve for initialization; a
// dropped request (spare mode, cursor row 0 or 3) never raises busy. Strobes
// are registered and show up in the cycle after their step.
// Reset (arst_n low) returns to idle and reloads the standard command words;
// the receiver cannot stall and cfg_ready is always high.
`include "char_lcd_nibble_sequencer_macros.svh"

module char_lcd_nibble_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] mode,
	input  logic [7:0] byte_value,
	input  logic [1:0] row,
	input  logic [7:0] column,
	output logic       strobe,
	output logic [3:0] nibble,
	output logic       reg_select,
	output logic       pre_wait,
	output logic [1:0] post_wait,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import clns_pkg::*;

	cfg_words_t        words;
	logic              run_q;
	logic [PC_W-1:0]   pc_q;
	logic [BYTE_W-1:0] opnd_q;     // request byte, or finished cursor address
	logic              strobe_q;
	logic [NIB_W-1:0]  nibble_q;
	logic              rs_q;
	logic              pre_q;
	logic [1:0]        post_q;
	logic              last_q;

	logic              accept;
	logic              entry_ok;
	logic [PC_W-1:0]   entry_pc;
	logic [BYTE_W-1:0] cursor_byte;
	uword_t            uw;
	logic [BYTE_W-1:0] src_byte;

	assign cfg_ready = 1'b1;

	clns_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.words     (words)
	);

	assign busy   = run_q;
	assign accept = start && !run_q;

	// column counts from 1; the minus one wraps in 8 bits
	assign cursor_byte = (column - 8'd1) | ((row == ROW_TWO) ? CURSOR_ROW2 : CURSOR_ROW1);

	// dispatch: jump to the mode's routine, or drop the request
	always_comb begin
		entry_ok = 1'b1;
		entry_pc = PC_DATA;
		unique case (mode)
			MODE_DATA:   entry_pc = PC_DATA;
			MODE_CMD:    entry_pc = PC_CMD;
			MODE_CURSOR: begin
				entry_pc = PC_CMD;
				entry_ok = (row == ROW_ONE) || (row == ROW_TWO);
			end
			MODE_CLEAR:  entry_pc = PC_CLEAR;
			MODE_HOME:   entry_pc = PC_HOME;
			MODE_INIT:   entry_pc = PC_INIT;
			default:     entry_ok = 1'b0;
		endcase
	end

	assign uw = ucode(pc_q);

	// operand mux driven by the control word
	always_comb begin
		unique case (uw.src)
			SRC_OPND:  src_byte = opnd_q;
			SRC_FSET:  src_byte = words.fset;
			SRC_DON:   src_byte = words.don;
			SRC_ENTRY: src_byte = words.entry;
			SRC_CLEAR: src_byte = words.clear;
			SRC_HOME:  src_byte = words.home;
			SRC_WAKE:  src_byte = WAKE_BYTE;
			SRC_FOUR:  src_byte = FOUR_BYTE;
			default:   src_byte = opnd_q;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pc_q  <= '0;
		end else if (accept) begin
			run_q <= entry_ok;
			pc_q  <= entry_pc;
		end else if (run_q) begin
			if (uw.done) begin
				run_q <= 1'b0;
			end else begin
				pc_q <= pc_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opnd_q <= (mode == MODE_CURSOR) ? cursor_byte : byte_value;
		end
	end

	// registered strobe outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			nibble_q <= uw.hi ? src_byte[7:4] : src_byte[3:0];
			rs_q     <= uw.rs;
			pre_q    <= uw.pre;
			post_q   <= uw.post;
			last_q   <= uw.done;
		end
	end

	assign strobe     = strobe_q;
	assign nibble     = nibble_q;
	assign reg_select = rs_q;
	assign pre_wait   = pre_q;
	assign post_wait  = post_q;
	assign last       = last_q;

	`CLNS_ASSERT_NXT(a_done_ends_run, run_q && uw.done, !run_q)
	`CLNS_ASSERT_NXT(a_step_gives_strobe, run_q, strobe)
	`CLNS_ASSERT_NXT(a_idle_no_strobe, !run_q, !strobe)
	`CLNS_ASSERT_IMP(a_last_when_idle, strobe && last, !busy)
	`CLNS_ASSERT_IMP(a_pre_not_last, strobe && pre_wait, !last && !reg_select)

endmodule

// File: rtl/clns_cfg_regs.sv
module clns_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	output clns_pkg::cfg_words_t words
);
	import clns_pkg::*;

	cfg_words_t words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q.fset  <= 8'h28;
			words_q.don   <= 8'h0E;
			words_q.entry <= 8'h06;
			words_q.clear <= 8'h01;
			words_q.home  <= 8'h02;
		end else if (cfg_valid) begin
			// unknown indexes drop the write
			unique case (cfg_index)
				CFG_FSET:  words_q.fset  <= cfg_data;
				CFG_DON:   words_q.don   <= cfg_data;
				CFG_ENTRY: words_q.entry <= cfg_data;
				CFG_CLEAR: words_q.clear <= cfg_data;
				CFG_HOME:  words_q.home  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign words = words_q;

endmodule

// File: tb/sv/tb_char_lcd_nibble_sequencer.sv
module tb_char_lcd_nibble_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	import clns_pkg::*;

	// Opcodes the block must ignore, and register indexes past the last register.
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam logic [2:0] CFG_SPARE_LO  = 3'd5;
	localparam logic [2:0] CFG_SPARE_HI  = 3'd7;

	// Command words after reset.
	localparam logic [7:0] FSET_RST  = 8'h28;
	localparam logic [7:0] DON_RST   = 8'h0E;
	localparam logic [7:0] ENTRY_RST = 8'h06;
	localparam logic [7:0] CLEAR_RST = 8'h01;
	localparam logic [7:0] HOME_RST  = 8'h02;

	// Longest request is initialization: dispatch plus twelve steps plus the
	// output register. Requests that drop to nothing never raise busy.
	localparam int SETTLE_CYCLES = 16;
	localparam int RUN_LIMIT_NS  = 400_000;

	localparam int RAND_PHASES    = 9;
	localparam int PHASE_REQUESTS = 45;

	// One strobe on the LCD bus, as the block should emit it.
	typedef struct packed {
		logic [3:0] nib;
		logic       rs;
		logic       pre;
		wait_t      post;
		logic       fin;
	} lcd_strobe_t;

	typedef enum logic {
		STEP_REQ,
		STEP_CFG
	} step_kind_t;

	// Where a request's expected strobes come from.
	typedef enum logic [1:0] {
		CHK_MODEL,  // computed by the local predictor
		CHK_BYTE,   // one byte, typed into the table
		CHK_NONE    // request must produce no strobe
	} chk_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic [2:0] mode;
		logic [7:0] bval;
		logic [1:0] crow;
		logic [7:0] ccol;
		logic [2:0] cidx;
		logic [7:0] cdata;
		chk_kind_t  chk;
		logic [7:0] xbyte;
		logic       xrs;
		wait_t      xpost;
	} lcd_step_t;

	localparam int DIRECTED_STEPS = 25;

	// Directed opening. Byte-sized results that are obvious from the spec are
	// typed in; initialization sequences and the arbitrary command go to the predictor.
	localparam lcd_step_t DIRECTED[DIRECTED_STEPS] = '{
		// defaults straight out of reset
		'{STEP_REQ, MODE_INIT,     8'h00, 2'd0, 8'd0,   CFG_FSET,     8'h00,
			CHK_MODEL, 8'h00, 1'b0, WAIT_NONE},
		'{STEP_REQ, MODE_CLEAR,    8'h00, 2'd0, 8'd0,   CFG_FSET,     8'h00,
			CHK_BYTE,  CLEAR_RST, 1'b0, WAIT_2MS},
		'{STEP_REQ, MODE_HOME,     8'hFF, 2'd3, 8'd255, CFG_FSET,     8'h00,
			CHK_BYTE,  HOME_RST, 1'b0, WAIT_2MS},
		// data and command byte extremes
		'{STEP_REQ, MODE_DATA,     8'h00, 2'd0, 8'd0,   CFG_FSET,     8'h00,
			CHK_BYTE,  8'h00, 1'b1, WAIT_NONE},
		'{STEP_REQ, MODE_DATA,     8'hFF, 2'd0, 8'd0,   CFG_FSET,     8'h00,
			CHK_BYTE,  8'hFF, 1'b1, WAIT_NONE},
		'{STEP_REQ, MODE_CMD,      8'hA5, 2'd1, 8'd7,   CFG_FSET,     8'h00,
			CHK_MODEL, 8'h00, 1'b0, WAIT_NONE},
		'{STEP_REQ, MODE_CMD,      8'hFF, 2'd0, 8'd0,   CFG_FSET,     8'h00,
			CHK_BYTE,  8'hFF, 1'b0, WAIT_NONE},
		// cursor: first column of each row, then column wrap at both ends
		'{STEP_REQ, MODE_CURSOR,   8'h00, 2'd1, 8'd1,   CFG_FSET,     8'h00,
			CHK_BYTE,  8'h80, 1'b0, WAIT_NONE},
		'{STEP_REQ, MODE_CURSOR,   8'h00, 2'd2, 8'd1,   CFG_FSET,     8'h00,
			CHK_BYTE,  8'hC0, 1'b0, WAIT_NONE},
		'{STEP_REQ, MODE_CURSOR,   8'hFF, 2'd1, 8'd0,   CFG_FSET,     8'h00,
			CHK_BYTE,  8'hFF, 1'b0, WAIT_NONE},
		'{STEP_REQ, MODE_CURSOR,   8'h00, 2'd2, 8'd255, CFG_FSET,     8'h00,
			CHK_BYTE,  8'hFE, 1'b0, WAIT_NONE},
		// rows the block does not act on, and unused opcodes
		'{STEP_REQ, MODE_CURSOR,   8'h00, 2'd0, 8'd5,   CFG_FSET,     8'h00,
			CHK_NONE,  8'h00, 1'b0, WAIT_NONE},
		'{STEP_REQ, MODE_CURSOR,   8'hFF, 2'd3, 8'd5,   CFG_FSET,     8'h00,
			CHK_NONE,  8'h00, 1'b0, WAIT_NONE},
		'{STEP_REQ, MODE_SPARE_LO, 8'hFF, 2'd1, 8'd1,   CFG_FSET,     8'h00,
			CHK_NONE,  8'h00, 1'b0, WAIT_NONE},
		'{STEP_REQ, MODE_SPARE_HI, 8'h00, 2'd2, 8'd255, CFG_FSET,     8'h00,
			CHK_NONE,  8'h00, 1'b0, WAIT_NONE},
		// every register to an extreme, then writes past the register file
		'{STEP_CFG, MODE_DATA,     8'h00, 2'd0, 8'd0,   CFG_FSET,     8'h00,
			CHK_MODEL, 8'h00, 1'b0, WAIT_NONE},
		'{STEP_CFG, MODE_DATA,     8'h00, 2'd0, 8'd0,   CFG_DON,      8'hFF,
			CHK_MODEL, 8'h00, 1'b0, WAIT_NONE},
		'{STEP_CFG, MODE_DATA,     8'h00, 2'd0, 8'd0,   CFG_ENTRY,    8'h00,
			CHK_MODEL, 8'h00, 1'b0, WAIT_NONE},
		'{STEP_CFG, MODE_DATA,     8'h00, 2'd0, 8'd0,   CFG_CLEAR,    8'hFF,
			CHK_MODEL, 8'h00, 1'b0, WAIT_NONE},
		'{STEP_CFG, MODE_DATA,     8'h00, 2'd0, 8'd0,   CFG_HOME,     8'h00,
			CHK_MODEL, 8'h00, 1'b0, WAIT_NONE},
		'{STEP_CFG, MODE_DATA,     8'h00, 2'd0, 8'd0,   CFG_SPARE_LO, 8'h55,
			CHK_MODEL, 8'h00, 1'b0, WAIT_NONE},
		'{STEP_CFG, MODE_DATA,     8'h00, 2'd0, 8'd0,   CFG_SPARE_HI, 8'hAA,
			CHK_MODEL, 8'h00, 1'b0, WAIT_NONE},
		// new words must show up in initialization, clear and home
		'{STEP_REQ, MODE_INIT,     8'hFF, 2'd3, 8'd255, CFG_FSET,     8'h00,
			CHK_MODEL, 8'h00, 1'b0, WAIT_NONE},
		'{STEP_REQ, MODE_CLEAR,    8'h00, 2'd0, 8'd0,   CFG_FSET,     8'h00,
			CHK_BYTE,  8'hFF, 1'b0, WAIT_2MS},
		'{STEP_REQ, MODE_HOME,     8'h00, 2'd0, 8'd0,   CFG_FSET,     8'h00,
			CHK_BYTE,  8'h00, 1'b0, WAIT_2MS}
	};

	// DUT ports; the inputs are known from time zero.
	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       start      = 1'b0;
	logic       busy;
	logic [2:0] mode       = '0;
	logic [7:0] byte_value = '0;
	logic [1:0] row        = '0;
	logic [7:0] column     = '0;
	logic       strobe;
	logic [3:0] nibble;
	logic       reg_select;
	logic       pre_wait;
	logic [1:0] post_wait;
	logic       last;
	logic       cfg_valid  = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index  = '0;
	logic [7:0] cfg_data   = '0;

	// Predictor state: its own copy of the command words.
	cfg_words_t  lcd_words;
	// Strobes owed by accepted requests, oldest first.
	lcd_strobe_t pending_strobes[$];

	int mismatches      = 0;
	int requests_sent   = 0;
	int strobes_checked = 0;
	int reg_writes      = 0;

	char_lcd_nibble_sequencer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.byte_value (byte_value),
		.row        (row),
		.column     (column),
		.strobe     (strobe),
		.nibble     (nibble),
		.reg_select (reg_select),
		.pre_wait   (pre_wait),
		.post_wait  (post_wait),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void push_nibble(logic [3:0] nib, logic rs, logic pre, wait_t post,
			logic fin);
		lcd_strobe_t s;
		s.nib  = nib;
		s.rs   = rs;
		s.pre  = pre;
		s.post = post;
		s.fin  = fin;
		pending_strobes.push_back(s);
	endfunction

	// A byte is two strobes, high nibble first; only the second carries the wait.
	function automatic void push_byte(logic [7:0] b, logic rs, wait_t post, logic fin);
		push_nibble(b[7:4], rs, 1'b0, WAIT_NONE, 1'b0);
		push_nibble(b[3:0], rs, 1'b0, post, fin);
	endfunction

	function automatic void expand_request(logic [2:0] m, logic [7:0] b, logic [1:0] r,
			logic [7:0] c);
		logic [7:0] pos;
		pos = c - 8'd1;  // columns count from 1, wraps at 0
		case (m)
			MODE_DATA:   push_byte(b, 1'b1, WAIT_NONE, 1'b1);
			MODE_CMD:    push_byte(b, 1'b0, WAIT_NONE, 1'b1);
			MODE_CURSOR: begin
				if (r == ROW_ONE)
					push_byte(pos | CURSOR_ROW1, 1'b0, WAIT_NONE, 1'b1);
				else if (r == ROW_TWO)
					push_byte(pos | CURSOR_ROW2, 1'b0, WAIT_NONE, 1'b1);
			end
			MODE_CLEAR:  push_byte(lcd_words.clear, 1'b0, WAIT_2MS, 1'b1);
			MODE_HOME:   push_byte(lcd_words.home, 1'b0, WAIT_2MS, 1'b1);
			MODE_INIT: begin
				// wake-up: long power-on wait, then 5 ms, 150 us, none
				push_nibble(WAKE_BYTE[3:0], 1'b0, 1'b1, WAIT_5MS, 1'b0);
				push_nibble(WAKE_BYTE[3:0], 1'b0, 1'b0, WAIT_150, 1'b0);
				push_nibble(WAKE_BYTE[3:0], 1'b0, 1'b0, WAIT_NONE, 1'b0);
				push_nibble(FOUR_BYTE[3:0], 1'b0, 1'b0, WAIT_NONE, 1'b0);
				push_byte(lcd_words.fset, 1'b0, WAIT_NONE, 1'b0);
				push_byte(lcd_words.don, 1'b0, WAIT_NONE, 1'b0);
				push_byte(lcd_words.clear, 1'b0, WAIT_2MS, 1'b0);
				push_byte(lcd_words.entry, 1'b0, WAIT_NONE, 1'b1);
			end
			default: ;  // spare opcodes are dropped
		endcase
	endfunction

	function automatic void store_word(logic [2:0] idx, logic [7:0] data);
		case (idx)
			CFG_FSET:  lcd_words.fset  = data;
			CFG_DON:   lcd_words.don   = data;
			CFG_ENTRY: lcd_words.entry = data;
			CFG_CLEAR: lcd_words.clear = data;
			CFG_HOME:  lcd_words.home  = data;
			default:   ;  // out of range, ignored
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Strobe checker: every strobe must match the oldest owed strobe.
	// ------------------------------------------------------------------

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : strobe_check
		lcd_strobe_t want;
		if (arst_n && strobe) begin
			if (pending_strobes.size() == 0) begin
				$error("unexpected strobe: nibble 0x%0h rs %0b last %0b",
					nibble, reg_select, last);
				mismatches++;
			end else begin
				want = pending_strobes.pop_front();
				check_field("nibble", want.nib, nibble);
				check_field("reg_select", want.rs, reg_select);
				check_field("pre_wait", want.pre, pre_wait);
				check_field("post_wait", want.post, post_wait);
				check_field("last", want.fin, last);
				strobes_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver tasks. All are entered and left just after a falling edge.
	// ------------------------------------------------------------------

	// Present one request and hold it until the block takes it. Expected
	// strobes are queued on the accepting edge.
	task automatic send_request(input lcd_step_t s);
		logic taken;
		start      = 1'b1;
		mode       = s.mode;
		byte_value = s.bval;
		row        = s.crow;
		column     = s.ccol;
		taken      = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			if (!taken)
				@(negedge clk);
		end
		case (s.chk)
			CHK_MODEL: expand_request(s.mode, s.bval, s.crow, s.ccol);
			CHK_BYTE:  push_byte(s.xbyte, s.xrs, s.xpost, 1'b1);
			default:   ;
		endcase
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic hold_off(input int cycles);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Wait until every owed strobe is in and the block is idle, then let it
	// settle in case a request that makes no strobe is still dispatching.
	task automatic drain_strobes();
		start = 1'b0;
		do
			@(posedge clk);
		while (pending_strobes.size() != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Only called while idle; the predictor takes the word on the same edge.
	task automatic write_register(input logic [2:0] idx, input logic [7:0] data);
		logic taken;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		taken     = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = cfg_ready;
			if (!taken)
				@(negedge clk);
		end
		store_word(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [7:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 8'h00;
		else if (r < 4)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Random request, weighted toward modes that put something on the bus.
	function automatic lcd_step_t random_request();
		lcd_step_t s;
		int unsigned r;
		s       = '0;
		s.kind  = STEP_REQ;
		s.chk   = CHK_MODEL;
		s.bval  = 8'($urandom);
		s.crow  = 2'($urandom);
		s.ccol  = 8'($urandom);
		r = $urandom_range(0, 99);
		if (r < 28)
			s.mode = MODE_DATA;
		else if (r < 46)
			s.mode = MODE_CMD;
		else if (r < 70)
			s.mode = MODE_CURSOR;
		else if (r < 79)
			s.mode = MODE_CLEAR;
		else if (r < 88)
			s.mode = MODE_HOME;
		else if (r < 96)
			s.mode = MODE_INIT;
		else
			s.mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;
		// cursor: mostly rows the block acts on, and the column wrap points
		if (s.mode == MODE_CURSOR) begin
			if ($urandom_range(0, 4) != 0)
				s.crow = ($urandom_range(0, 1) != 0) ? ROW_TWO : ROW_ONE;
			r = $urandom_range(0, 9);
			if (r == 0)
				s.ccol = 8'd0;
			else if (r == 1)
				s.ccol = 8'd1;
			else if (r == 2)
				s.ccol = 8'd255;
		end
		return s;
	endfunction

	function automatic bit makes_strobes(lcd_step_t s);
		if (s.mode == MODE_SPARE_LO || s.mode == MODE_SPARE_HI)
			return 1'b0;
		if (s.mode == MODE_CURSOR)
			return s.crow == ROW_ONE || s.crow == ROW_TWO;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin : main_seq
		lcd_step_t s;
		int        counted;
		int        burst;
		bit        gapless;

		lcd_words.fset  = FSET_RST;
		lcd_words.don   = DON_RST;
		lcd_words.entry = ENTRY_RST;
		lcd_words.clear = CLEAR_RST;
		lcd_words.home  = HOME_RST;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table; register writes only once the bus has gone quiet.
		for (int i = 0; i < DIRECTED_STEPS; i++) begin
			if (DIRECTED[i].kind == STEP_CFG) begin
				drain_strobes();
				write_register(DIRECTED[i].cidx, DIRECTED[i].cdata);
			end else begin
				send_request(DIRECTED[i]);
				if ($urandom_range(0, 2) == 0)
					hold_off($urandom_range(1, 3));
			end
		end

		// Random phases. Each starts from an idle block with fresh command
		// words (draining here is also the full pause with nothing owed).
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_strobes();
			for (int k = 0; k < 5; k++)
				write_register(3'(k), pick_word());
			if ($urandom_range(0, 2) == 0)
				write_register(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 8'($urandom));

			gapless = (ph % 3 == 1);  // back-to-back requests in some phases
			counted = 0;
			while (counted < PHASE_REQUESTS) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && counted < PHASE_REQUESTS; b++) begin
					s = random_request();
					send_request(s);
					if (makes_strobes(s))
						counted++;
				end
				if (!gapless && $urandom_range(0, 9) < 7)
					hold_off($urandom_range(1, 20));
			end
		end

		drain_strobes();

		$display("covered %0d requests over %0d random phases, %0d register writes",
			requests_sent, RAND_PHASES, reg_writes);
		$display("checked %0d strobes, %0d mismatches", strobes_checked, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#(RUN_LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/clns_pkg.sv
rtl/clns_cfg_regs.sv
rtl/char_lcd_nibble_sequencer.sv
tb/sv/tb_char_lcd_nibble_sequencer.sv
